FILE: hdl/lskv_pkg.sv
// shared constants and request codes for the key/value table
`default_nettype none
package lskv_pkg;

  localparam int ENTRIES    = 256;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int CNT_BITS   = $clog2(ENTRIES + 1);

  // request codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_CHOOSE = 2'd3;

endpackage
`default_nettype wire

FILE: hdl/linear_search_key_value_table_unit.sv
// key/value table with linear search over an unsorted packed array
//
// usage:
//   in_*  : one request word per handshake (action, key, value); the
//           block takes a word only when its sequencer is idle
//   out_* : one result word per request (hit, read_value, chosen_key,
//           now_empty, full_error), held in an output register
//   scan:  insert, lookup and remove scan the stored keys through a
//           single memory read port and one key comparator, one slot per
//           cycle, stopping at the first hit or after the last stored
//           entry; a hit on remove then reads the last entry and moves it
//           into the freed slot; choose-key reads the key in slot 0, and
//           on an empty table it goes straight to its result
//   requests: one at a time; a new word is taken only after the last
//           result has gone into the output register
//   reset: synchronous, active low; empties the table (count to zero),
//           the stored keys and values are not cleared
//   stall: a new request may be taken while a result waits in the output
//           register; a finished request waits in its last state until
//           the receiver takes the pending result
`default_nettype none
module linear_search_key_value_table_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_action,
  input  wire logic [lskv_pkg::KEY_BITS-1:0]   in_key,
  input  wire logic [lskv_pkg::VALUE_BITS-1:0] in_value,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_hit,
  output logic [31:0]                          out_read_value,
  output logic [31:0]                          out_chosen_key,
  output logic                                 out_now_empty,
  output logic                                 out_full_error
);
  import lskv_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_REM_RD = 3'd2;
  localparam logic [2:0] ST_REM_WR = 3'd3;
  localparam logic [2:0] ST_CHOOSE = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // storage: one write port, one registered read port
  logic [KEY_BITS-1:0]   key_mem [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem [ENTRIES];

  logic [2:0]            state_r, state_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [CNT_BITS-1:0]   scan_idx_r, scan_idx_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IDX_BITS-1:0]   rd_idx_r;
  logic [KEY_BITS-1:0]   rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic [IDX_BITS-1:0]   rd_addr;

  // latched request
  logic [1:0]            act_r, act_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [IDX_BITS-1:0]   slot_r, slot_nxt;

  // result held until the output register is free
  logic                  res_hit_r, res_hit_nxt;
  logic [31:0]           res_val_r, res_val_nxt;
  logic [31:0]           res_ckey_r, res_ckey_nxt;
  logic                  res_full_r, res_full_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic [31:0]           out_val_r, out_val_nxt;
  logic [31:0]           out_ckey_r, out_ckey_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic                  out_full_r, out_full_nxt;

  // memory write port controls
  logic                  mem_we;
  logic [IDX_BITS-1:0]   mem_wa;
  logic [KEY_BITS-1:0]   mem_wk;
  logic [VALUE_BITS-1:0] mem_wv;

  logic                  key_match;
  logic                  scan_issued_all;
  logic [CNT_BITS-1:0]   last_cnt;

  assign key_match       = rd_vld_r && (rd_key_r == key_r);
  assign scan_issued_all = (scan_idx_r == count_r);
  assign last_cnt        = count_r - CNT_BITS'(1);

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_val_r;
  assign out_chosen_key  = out_ckey_r;
  assign out_now_empty   = out_empty_r;
  assign out_full_error  = out_full_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_idx_nxt  = scan_idx_r;
    rd_vld_nxt    = 1'b0;
    rd_addr       = '0;
    act_nxt       = act_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    slot_nxt      = slot_r;
    res_hit_nxt   = res_hit_r;
    res_val_nxt   = res_val_r;
    res_ckey_nxt  = res_ckey_r;
    res_full_nxt  = res_full_r;
    out_valid_nxt = out_valid_r;
    out_hit_nxt   = out_hit_r;
    out_val_nxt   = out_val_r;
    out_ckey_nxt  = out_ckey_r;
    out_empty_nxt = out_empty_r;
    out_full_nxt  = out_full_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wk        = key_r;
    mem_wv        = val_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // read address rests at slot 0 so choose finds its key registered
        if (in_valid) begin
          act_nxt      = in_action;
          key_nxt      = in_key;
          val_nxt      = in_value;
          scan_idx_nxt = '0;
          res_hit_nxt  = 1'b0;
          res_val_nxt  = '0;
          res_ckey_nxt = '0;
          res_full_nxt = 1'b0;
          if (in_action == ACT_CHOOSE) begin
            state_nxt = (count_r == '0) ? ST_DONE : ST_CHOOSE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, compare the word read last cycle
        if (!scan_issued_all) begin
          rd_addr      = scan_idx_r[IDX_BITS-1:0];
          rd_vld_nxt   = 1'b1;
          scan_idx_nxt = scan_idx_r + CNT_BITS'(1);
        end
        if (key_match) begin
          rd_vld_nxt = 1'b0;
          slot_nxt   = rd_idx_r;
          case (act_r)
            ACT_INSERT: begin
              mem_we      = 1'b1;
              mem_wa      = rd_idx_r;
              res_hit_nxt = 1'b1;
              state_nxt   = ST_DONE;
            end
            ACT_LOOKUP: begin
              res_hit_nxt = 1'b1;
              res_val_nxt = 32'(rd_val_r);
              state_nxt   = ST_DONE;
            end
            default: begin
              res_hit_nxt = 1'b1;
              state_nxt   = ST_REM_RD;
            end
          endcase
        end else if (!rd_vld_r && scan_issued_all) begin
          // miss
          rd_vld_nxt = 1'b0;
          state_nxt  = ST_DONE;
          if (act_r == ACT_INSERT) begin
            if (count_r < CNT_BITS'(ENTRIES)) begin
              mem_we    = 1'b1;
              mem_wa    = count_r[IDX_BITS-1:0];
              count_nxt = count_r + CNT_BITS'(1);
            end else begin
              res_full_nxt = 1'b1;
            end
          end
        end
      end
      ST_REM_RD: begin
        rd_addr   = last_cnt[IDX_BITS-1:0];
        state_nxt = ST_REM_WR;
      end
      ST_REM_WR: begin
        // last entry fills the freed slot
        mem_we    = 1'b1;
        mem_wa    = slot_r;
        mem_wk    = rd_key_r;
        mem_wv    = rd_val_r;
        count_nxt = last_cnt;
        state_nxt = ST_DONE;
      end
      ST_CHOOSE: begin
        res_hit_nxt  = 1'b1;
        res_ckey_nxt = 32'(rd_key_r);
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_val_nxt   = res_val_r;
          out_ckey_nxt  = res_ckey_r;
          out_empty_nxt = (count_r == '0);
          out_full_nxt  = res_full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // storage ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_wa] <= mem_wk;
      val_mem[mem_wa] <= mem_wv;
    end
  end

  always_ff @(posedge clk) begin
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
    rd_idx_r <= rd_addr;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    act_r       <= act_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    slot_r      <= slot_nxt;
    res_hit_r   <= res_hit_nxt;
    res_val_r   <= res_val_nxt;
    res_ckey_r  <= res_ckey_nxt;
    res_full_r  <= res_full_nxt;
    out_hit_r   <= out_hit_nxt;
    out_val_r   <= out_val_nxt;
    out_ckey_r  <= out_ckey_nxt;
    out_empty_r <= out_empty_nxt;
    out_full_r  <= out_full_nxt;
  end

endmodule
`default_nettype wire

FILE: tb/lskv_checker.sv
// result checker for the key/value table: predicts each result word and compares it
`timescale 1ns / 1ps
module lskv_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [1:0]                      in_action,
  input  logic [lskv_pkg::KEY_BITS-1:0]   in_key,
  input  logic [lskv_pkg::VALUE_BITS-1:0] in_value,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_hit,
  input  logic [31:0]                     out_read_value,
  input  logic [31:0]                     out_chosen_key,
  input  logic                            out_now_empty,
  input  logic                            out_full_error,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);
  import lskv_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic [31:0] chosen_key;
    logic        now_empty;
    logic        full_error;
  } table_result_t;

  logic [KEY_BITS-1:0]   slot_key   [ENTRIES];
  logic [VALUE_BITS-1:0] slot_value [ENTRIES];
  int unsigned           used_slots = 0;
  table_result_t         expected_q [$];
  int                    fails = 0;
  int                    seen = 0;

  assign fail_count = fails;
  assign checked    = seen;

  function automatic int find_key(input logic [KEY_BITS-1:0] key);
    for (int i = 0; i < used_slots; i++)
      if (slot_key[i] == key) return i;
    return -1;
  endfunction

  // applies one request to the predicted table and returns its result word
  function automatic table_result_t apply_request(input logic [1:0] act,
                                                  input logic [KEY_BITS-1:0] key,
                                                  input logic [VALUE_BITS-1:0] value);
    table_result_t res;
    int slot;
    res  = '0;
    slot = find_key(key);
    case (act)
      ACT_INSERT: begin
        if (slot >= 0) begin
          slot_value[slot] = value;
          res.hit = 1'b1;
        end else if (used_slots < ENTRIES) begin
          slot_key[used_slots]   = key;
          slot_value[used_slots] = value;
          used_slots++;
        end else begin
          res.full_error = 1'b1;
        end
      end
      ACT_LOOKUP: begin
        if (slot >= 0) begin
          res.hit        = 1'b1;
          res.read_value = slot_value[slot];
        end
      end
      ACT_REMOVE: begin
        // last entry fills the hole
        if (slot >= 0) begin
          slot_key[slot]   = slot_key[used_slots-1];
          slot_value[slot] = slot_value[used_slots-1];
          used_slots--;
          res.hit = 1'b1;
        end
      end
      ACT_CHOOSE: begin
        if (used_slots > 0) begin
          res.hit        = 1'b1;
          res.chosen_key = slot_key[0];
        end
      end
    endcase
    res.now_empty = (used_slots == 0);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    fails++;
    $display("%0t ns mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      used_slots = 0;
      expected_q.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          flag_mismatch("result word with nothing outstanding", out_read_value, 32'h0);
        end else begin
          want = expected_q.pop_front();
          seen++;
          if (out_hit !== want.hit)
            flag_mismatch("hit", out_hit, want.hit);
          if (out_read_value !== want.read_value)
            flag_mismatch("read_value", out_read_value, want.read_value);
          if (out_chosen_key !== want.chosen_key)
            flag_mismatch("chosen_key", out_chosen_key, want.chosen_key);
          if (out_now_empty !== want.now_empty)
            flag_mismatch("now_empty", out_now_empty, want.now_empty);
          if (out_full_error !== want.full_error)
            flag_mismatch("full_error", out_full_error, want.full_error);
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(apply_request(in_action, in_key, in_value));
      pending <= expected_q.size();
    end
  end

endmodule

FILE: tb/tb_linear_search_key_value_table_unit.sv
// top of the key/value table testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module tb_linear_search_key_value_table_unit;
  import lskv_pkg::*;

  // a request can scan every slot, so allow many full scans without any word moving
  localparam int STALL_LIMIT = 16 * (ENTRIES + 8);
  // tail wait after the last result: one full scan plus slack
  localparam int TAIL_CYCLES = ENTRIES + 16;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_action = ACT_INSERT;
  logic [KEY_BITS-1:0]   in_key = '0;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_hit;
  logic [31:0]           out_read_value;
  logic [31:0]           out_chosen_key;
  logic                  out_now_empty;
  logic                  out_full_error;

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping: which keys the table should hold, used to pick keys, steer fill and drain and track peak fill
  logic [31:0] stored_keys [$];
  int          sent_per_action [4];
  int          peak_fill = 0;
  int          full_inserts = 0;
  int          burst_left = 0;
  bit          idle_on = 1'b1;
  int          quiet_cycles = 0;
  int          rcv_cycle = 0;

  always #5 clk = ~clk;

  linear_search_key_value_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_chosen_key  (out_chosen_key),
    .out_now_empty   (out_now_empty),
    .out_full_error  (out_full_error)
  );

  lskv_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_chosen_key  (out_chosen_key),
    .out_now_empty   (out_now_empty),
    .out_full_error  (out_full_error),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked)
  );

  // receiver: rotates through always ready, coin flip, mostly stalled and a
  // fixed 3-of-7 pattern, so stalls land on every phase of a scan
  always @(posedge clk) begin
    rcv_cycle <= rcv_cycle + 1;
    case ((rcv_cycle / 600) % 4)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((rcv_cycle % 7) < 3);
    endcase
  end

  // watchdog: cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAIL linear_search_key_value_table_unit");
        $finish;
      end
    end
  end

  function automatic int shadow_find(input logic [31:0] key);
    foreach (stored_keys[i])
      if (stored_keys[i] == key) return i;
    return -1;
  endfunction

  function automatic logic [31:0] any_stored_key();
    if (stored_keys.size() == 0) return $urandom;
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // keeps the key list in step with what the table should hold
  task automatic note_request(input logic [1:0] act, input logic [31:0] key);
    int idx;
    idx = shadow_find(key);
    sent_per_action[act]++;
    if (act == ACT_INSERT && idx < 0) begin
      if (stored_keys.size() < ENTRIES) stored_keys.push_back(key);
      else full_inserts++;
    end else if (act == ACT_REMOVE && idx >= 0) begin
      stored_keys.delete(idx);
    end
    if (stored_keys.size() > peak_fill) peak_fill = stored_keys.size();
  endtask

  // one request word; while idle_on is set, bursts of random length with random gaps between them
  task automatic send_word(input logic [1:0] act, input logic [31:0] key,
                           input logic [31:0] value);
    if (idle_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_key    <= key;
    in_value  <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    note_request(act, key);
  endtask

  // hold the sender off until every result word has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // mixed traffic over a small key set, so hits and misses both happen often
  task automatic churn(input int n, input int key_set);
    logic [31:0] churn_keys [$];
    logic [31:0] k;
    int          r;
    repeat (key_set) churn_keys.push_back($urandom);
    repeat (n) begin
      r = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) == 0) ? $urandom : churn_keys[$urandom_range(0, key_set - 1)];
      if (r < 35)      send_word(ACT_INSERT, k, $urandom);
      else if (r < 62) send_word(ACT_LOOKUP, k, $urandom);
      else if (r < 88) send_word(ACT_REMOVE, k, $urandom);
      else             send_word(ACT_CHOOSE, $urandom, $urandom);
    end
  endtask

  // fill the table to capacity, work on it while full, then empty it again
  task automatic fill_and_drain();
    int r;
    while (stored_keys.size() < ENTRIES) begin
      if ($urandom_range(0, 6) == 0) send_word(ACT_LOOKUP, any_stored_key(), $urandom);
      else                           send_word(ACT_INSERT, $urandom, $urandom);
    end
    repeat (24) begin
      r = $urandom_range(0, 5);
      case (r)
        0, 1: send_word(ACT_INSERT, $urandom, $urandom);          // dropped, table full
        2:    send_word(ACT_INSERT, any_stored_key(), $urandom);  // update still allowed
        3:    send_word(ACT_LOOKUP, any_stored_key(), $urandom);
        4:    send_word(ACT_CHOOSE, $urandom, $urandom);
        default: begin
          // free one slot and take it again
          send_word(ACT_REMOVE, any_stored_key(), $urandom);
          send_word(ACT_INSERT, $urandom, $urandom);
        end
      endcase
    end
    while (stored_keys.size() > 0) begin
      r = $urandom_range(0, 99);
      if (r < 80)      send_word(ACT_REMOVE, any_stored_key(), $urandom);
      else if (r < 90) send_word(ACT_REMOVE, $urandom, $urandom);
      else if (r < 95) send_word(ACT_LOOKUP, any_stored_key(), $urandom);
      else             send_word(ACT_CHOOSE, $urandom, $urandom);
    end
    // empty table once more, all three kinds of miss
    send_word(ACT_CHOOSE, $urandom, $urandom);
    send_word(ACT_LOOKUP, $urandom, $urandom);
    send_word(ACT_REMOVE, $urandom, $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extreme keys and values, update, remove from
    // the last slot and from slot 0, misses of every kind
    send_word(ACT_CHOOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    send_word(ACT_LOOKUP, 32'h0000_0000, 32'h5A5A_5A5A);
    send_word(ACT_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000);
    send_word(ACT_CHOOSE, 32'h1234_5678, 32'h8765_4321);
    send_word(ACT_INSERT, 32'h5A5A_5A5A, 32'h1234_5678);
    send_word(ACT_REMOVE, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
    send_word(ACT_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_CHOOSE, 32'h0000_0000, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'h1234_5678, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(ACT_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(ACT_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'h8000_0000, 32'h0000_0000);
    send_word(ACT_CHOOSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // random traffic on a small table
    churn(400, 12);
    wait_for_results();

    // deep part: whole capacity, full table, drain back to empty
    fill_and_drain();

    // back to back with no sender gaps, then gaps again on a wider key set
    idle_on = 1'b0;
    churn(300, 8);
    idle_on = 1'b1;
    wait_for_results();
    churn(300, 40);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("requests: %0d insert, %0d lookup, %0d remove, %0d choose; %0d results checked",
             sent_per_action[ACT_INSERT], sent_per_action[ACT_LOOKUP],
             sent_per_action[ACT_REMOVE], sent_per_action[ACT_CHOOSE], checked);
    $display("table reached %0d of %0d entries, %0d new-key inserts hit a full table",
             peak_fill, ENTRIES, full_inserts);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS linear_search_key_value_table_unit");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("FAIL linear_search_key_value_table_unit");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/lskv_pkg.sv
hdl/linear_search_key_value_table_unit.sv
tb/lskv_checker.sv
tb/tb_linear_search_key_value_table_unit.sv
